FILE: rtl/core/mfr_pkg.sv
// Shared types, codes and constants of the modem request frame receiver.
`default_nettype none

package mfr_pkg;

  // Frame bytes
  localparam logic [7:0] BYTE_REQ   = 8'h43;  // 'C' preamble
  localparam logic [7:0] BYTE_SOH   = 8'h01;
  localparam logic [7:0] BYTE_BCAST = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_HIGH  = 2'd0;
  localparam logic [1:0] CFG_OWN_MID   = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN   = 2'd2;
  localparam logic [1:0] CFG_GAP_LIMIT = 2'd3;

  // Configuration reset values
  localparam logic [7:0] MAX_LEN_RST   = 8'd140;
  localparam logic [7:0] GAP_LIMIT_RST = 8'd3;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // Receiver phase, one-hot
  typedef enum logic [6:0] {
    PH_HUNT = 7'b0000001,
    PH_PRE  = 7'b0000010,
    PH_SEQ  = 7'b0000100,
    PH_ADDR = 7'b0001000,
    PH_LEN  = 7'b0010000,
    PH_DATA = 7'b0100000,
    PH_CRC  = 7'b1000000
  } phase_t;

  // Configuration registers as seen by the parser
  typedef struct packed {
    logic [31:0] own_high;
    logic [23:0] own_mid;
    logic [7:0]  max_len;
    logic [7:0]  gap_limit;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic       op;       // 0 byte, 1 tick
    logic [7:0] rx_byte;
  } item_t;

  // One result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [7:0]  position;
    logic [7:0]  sequence_res;
    logic        broadcast;
    logic [63:0] address;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/mfr_in_stage.sv
// Input register of the frame receiver: holds one accepted word.
`default_nettype none

module mfr_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mfr_pkg::item_t in_item,
  input  wire logic          take,      // parser consumes the held word
  output logic               valid,
  output mfr_pkg::item_t     item
);
  import mfr_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Free when empty or when the held word leaves this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

`default_nettype wire

FILE: rtl/core/mfr_parser.sv
// Frame parser: receive state and per-word decode of the request frame.
`default_nettype none

module mfr_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,   // held word is consumed this cycle
  input  wire mfr_pkg::item_t item,
  input  wire mfr_pkg::cfg_t  cfg,
  output logic                res_vld,
  output mfr_pkg::res_t       res
);
  import mfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        bcast_r, bcast_nxt;
  logic        match_r, match_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  chk_hi_r, chk_hi_nxt;
  logic [31:0] tail_r, tail_nxt;
  logic [7:0]  gap_r, gap_nxt;

  logic        in_frame;
  logic [7:0]  b;
  logic [7:0]  gap_inc;
  logic [2:0]  idx;
  logic [7:0]  own_b;
  logic [7:0]  count_inc;
  logic [15:0] got;
  logic        fail;
  logic        emit;
  kind_t       emit_kind;
  logic [7:0]  emit_value;
  logic [7:0]  emit_pos;

  assign b         = item.rx_byte;
  assign in_frame  = (phase_r == PH_SEQ) || (phase_r == PH_ADDR) || (phase_r == PH_LEN) ||
                     (phase_r == PH_DATA) || (phase_r == PH_CRC);
  assign gap_inc   = (gap_r == 8'hFF) ? gap_r : gap_r + 8'd1;
  assign idx       = count_r[2:0];
  assign count_inc = count_r + 8'd1;
  assign got       = {chk_hi_r, b};

  // Own address byte for the current address position
  always_comb begin
    unique case (idx)
      3'd0:    own_b = cfg.own_high[31:24];
      3'd1:    own_b = cfg.own_high[23:16];
      3'd2:    own_b = cfg.own_high[15:8];
      3'd3:    own_b = cfg.own_high[7:0];
      3'd4:    own_b = cfg.own_mid[23:16];
      3'd5:    own_b = cfg.own_mid[15:8];
      3'd6:    own_b = cfg.own_mid[7:0];
      default: own_b = cfg.own_mid[7:0];
    endcase
  end

  // Next state and result decode
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    bcast_nxt  = bcast_r;
    match_nxt  = match_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    chk_hi_nxt = chk_hi_r;
    tail_nxt   = tail_r;
    gap_nxt    = gap_r;
    fail       = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_DATA;
    emit_value = 8'd0;
    emit_pos   = 8'd0;

    if (item.op) begin
      // timer tick
      gap_nxt = gap_inc;
      if (in_frame && (gap_inc >= cfg.gap_limit)) begin
        fail = 1'b1;
      end
    end else begin
      if (in_frame) begin
        gap_nxt = 8'd0;
        sum_nxt = sum_r + {8'd0, b};
      end
      unique case (phase_r)
        PH_PRE: begin
          if (b == BYTE_REQ) begin
            phase_nxt = PH_PRE;
          end else if (b != BYTE_SOH) begin
            fail = 1'b1;
          end else begin
            phase_nxt = PH_SEQ;
            count_nxt = 8'd0;
            gap_nxt   = 8'd0;
            sum_nxt   = {8'd0, BYTE_SOH};
            bcast_nxt = 1'b1;
            match_nxt = 1'b1;
            seq_nxt   = 8'd0;
            len_nxt   = 8'd0;
            tail_nxt  = 32'd0;
          end
        end
        PH_SEQ: begin
          if (count_r == 8'd0) begin
            seq_nxt   = b;
            count_nxt = 8'd1;
          end else if (b != ~seq_r) begin
            fail = 1'b1;
          end else begin
            count_nxt = 8'd0;
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (!idx[2]) begin
            bcast_nxt = bcast_r && (b == BYTE_BCAST);
            match_nxt = match_r && (b == own_b);
            if (!bcast_nxt && !match_nxt) begin
              fail = 1'b1;
            end
          end else begin
            tail_nxt = {tail_r[23:0], b};
            if ((idx != 3'd7) && !bcast_r && (b != own_b)) begin
              fail = 1'b1;
            end
          end
          if (idx == 3'd7) begin
            count_nxt = 8'd0;
            phase_nxt = PH_LEN;
          end else begin
            count_nxt = {5'd0, idx + 3'd1};
          end
        end
        PH_LEN: begin
          if (b > cfg.max_len) begin
            fail = 1'b1;
          end else begin
            len_nxt   = b;
            count_nxt = 8'd0;
            phase_nxt = (b == 8'd0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          emit       = 1'b1;
          emit_kind  = KIND_DATA;
          emit_value = b;
          emit_pos   = count_r;
          if (count_inc >= len_r) begin
            count_nxt = 8'd0;
            phase_nxt = PH_CRC;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_CRC: begin
          // checksum bytes are not part of the sum
          sum_nxt = sum_r;
          if (count_r == 8'd0) begin
            chk_hi_nxt = b;
            count_nxt  = 8'd1;
          end else begin
            emit       = 1'b1;
            emit_kind  = (got == sum_r) ? KIND_GOOD : KIND_BAD;
            emit_value = len_r;
            count_nxt  = 8'd0;
            phase_nxt  = PH_HUNT;
          end
        end
        default: begin
          // hunting for the preamble
          phase_nxt = (b == BYTE_REQ) ? PH_PRE : PH_HUNT;
        end
      endcase
    end

    if (fail) begin
      phase_nxt = PH_HUNT;
    end
  end

  // Result word
  always_comb begin
    res_vld = fail || emit;
    if (fail) begin
      res      = '0;
      res.kind = KIND_ERR;
    end else begin
      res.kind         = emit_kind;
      res.value        = emit_value;
      res.position     = emit_pos;
      res.sequence_res = seq_r;
      res.broadcast    = bcast_r;
      res.address      = {(bcast_r ? 32'hFFFF_FFFF : cfg.own_high), tail_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      count_r  <= 8'd0;
      bcast_r  <= 1'b0;
      match_r  <= 1'b0;
      seq_r    <= 8'd0;
      len_r    <= 8'd0;
      sum_r    <= 16'd0;
      chk_hi_r <= 8'd0;
      tail_r   <= 32'd0;
      gap_r    <= 8'd0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      bcast_r  <= bcast_nxt;
      match_r  <= match_nxt;
      seq_r    <= seq_nxt;
      len_r    <= len_nxt;
      sum_r    <= sum_nxt;
      chk_hi_r <= chk_hi_nxt;
      tail_r   <= tail_nxt;
      gap_r    <= gap_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mfr_out_stage.sv
// Result register of the frame receiver: holds one word for the sink.
`default_nettype none

module mfr_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,      // new result written this cycle
  input  wire mfr_pkg::res_t res_in,
  output logic               ready,     // can take a result this cycle
  output logic               out_valid,
  input  wire logic          out_ready,
  output mfr_pkg::res_t      res_out
);
  import mfr_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign ready = !valid_r || out_ready;

  // Hold until taken; a load replaces a word that leaves this cycle
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

FILE: rtl/core/modem_request_frame_receiver_unit.sv
// Top level of the modem request frame receiver.
//
// Input stream: one word per received UART byte (in_tuser = 0, in_tdata = byte)
// or per 100 ms timer tick (in_tuser = 1). The receiver hunts for a 'C'
// preamble, checks SOH, the sequence byte and its complement, the address
// (own ID or broadcast), the length, then passes each data byte out as it
// arrives and closes the frame with a good, bad-checksum or error word.
// Output stream: out_tuser holds the result kind, out_tdata the fields.
// An accepted word is held in the input register and decoded by the parser
// into the result register, from which the sink takes it. One word is taken
// every cycle unless a word that gives a result finds the result register full,
// set by the single pass from input register through parser into result register.
// A stalled sink holds the result register; the input side keeps taking words
// that give no result and stops on the first one that does.
// Reset (rst_n low, synchronous) empties both registers, puts the receiver in
// preamble hunt and loads the configuration defaults (max length 140, gap
// limit 3, own address zero). Configuration is written through cfg_we, cfg_addr
// and cfg_wdata while no word is in flight: the user must keep to this, the block does not enforce it.
`default_nettype none

module modem_request_frame_receiver_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  wire logic        in_tuser,    // [0] op
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,   // [7:0] value, [15:8] position,
                                        // [23:16] sequence_res, [24] broadcast,
                                        // [88:25] address, [95:89] zero
  output logic [1:0]       out_tuser,   // [1:0] kind
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);
  import mfr_pkg::*;

  logic [31:0] own_high_r;
  logic [23:0] own_mid_r;
  logic [7:0]  max_len_r;
  logic [7:0]  gap_limit_r;
  cfg_t        cfg;

  item_t in_item;
  item_t held_item;
  logic  held_vld;
  logic  advance;
  logic  res_vld;
  res_t  res;
  logic  out_ready_int;
  res_t  out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_high_r  <= 32'd0;
      own_mid_r   <= 24'd0;
      max_len_r   <= MAX_LEN_RST;
      gap_limit_r <= GAP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OWN_HIGH:  own_high_r  <= cfg_wdata;
        CFG_OWN_MID:   own_mid_r   <= cfg_wdata[23:0];
        CFG_MAX_LEN:   max_len_r   <= cfg_wdata[7:0];
        CFG_GAP_LIMIT: gap_limit_r <= cfg_wdata[7:0];
        default:       own_high_r  <= own_high_r;
      endcase
    end
  end

  assign cfg.own_high  = own_high_r;
  assign cfg.own_mid   = own_mid_r;
  assign cfg.max_len   = max_len_r;
  assign cfg.gap_limit = gap_limit_r;

  assign in_item.op      = in_tuser;
  assign in_item.rx_byte = in_tdata;

  // Held word moves on unless its result finds the result register full
  assign advance = held_vld && (!res_vld || out_ready_int);

  mfr_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .take     (advance),
    .valid    (held_vld),
    .item     (held_item)
  );

  mfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  mfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_vld),
    .res_in    (res),
    .ready     (out_ready_int),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (out_res)
  );

  // Pack the result word
  assign out_tuser = out_res.kind;
  assign out_tdata = {7'd0, out_res.address, out_res.broadcast, out_res.sequence_res,
                      out_res.position, out_res.value};

endmodule

`default_nettype wire

FILE: test/tb_modem_request_frame_receiver_unit.sv
// Testbench for the modem request frame receiver: random and directed frames against a predictor.
`timescale 1ns / 100ps

module tb_modem_request_frame_receiver_unit;
  import mfr_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum int {ADDR_OWN, ADDR_BCAST, ADDR_NEAR, ADDR_RANDOM} addr_mode_t;
  typedef enum int {FL_NONE, FL_CSUM, FL_CPL, FL_CUT} flaw_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  modem_request_frame_receiver_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Expected result words, oldest first
  res_t frame_results_q[$];
  int   mismatches = 0;
  int   words_sent = 0;
  bit   idle_on = 1'b1;
  bit   stall_on = 1'b1;

  // Receiver copy: configuration
  logic [31:0] own_high;
  logic [23:0] own_mid;
  logic [7:0]  max_len;
  logic [7:0]  gap_lim;

  // Receiver copy: frame state
  phase_t      rx_phase;
  logic [7:0]  rx_count;
  logic        rx_bcast;
  logic        rx_match;
  logic [7:0]  rx_seq;
  logic [7:0]  rx_len;
  logic [15:0] rx_sum;
  logic [7:0]  rx_chk_hi;
  logic [31:0] rx_tail;
  logic [7:0]  rx_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Byte i of the own modem address, byte 0 first
  function automatic logic [7:0] own_byte(input int i);
    if (i < 4) return own_high[8*(3-i) +: 8];
    return own_mid[8*(6-i) +: 8];
  endfunction

  function automatic void push_frame_word(input kind_t k, input logic [7:0] val,
                                          input logic [7:0] pos);
    res_t r;
    r.kind         = k;
    r.value        = val;
    r.position     = pos;
    r.sequence_res = rx_seq;
    r.broadcast    = rx_bcast;
    r.address      = {rx_bcast ? 32'hFFFF_FFFF : own_high, rx_tail};
    frame_results_q.push_back(r);
  endfunction

  // Receive error: all fields zero, back to hunting
  function automatic void push_rx_error();
    res_t r;
    r = '0;
    r.kind = KIND_ERR;
    frame_results_q.push_back(r);
    rx_phase = PH_HUNT;
  endfunction

  // Advance the receiver copy by one accepted word
  function automatic void predict_frame(input logic op, input logic [7:0] b);
    logic        in_frame;
    logic [2:0]  slot;
    logic [15:0] got;
    in_frame = (rx_phase != PH_HUNT) && (rx_phase != PH_PRE);
    if (op == OP_TICK) begin
      if (rx_gap != 8'hFF) rx_gap = rx_gap + 8'd1;
      if (in_frame && rx_gap >= gap_lim) push_rx_error();
      return;
    end
    if (in_frame) begin
      rx_gap = 8'd0;
      rx_sum = rx_sum + b;
    end
    case (rx_phase)
      PH_PRE: begin
        if (b == BYTE_REQ) return;
        if (b != BYTE_SOH) begin
          push_rx_error();
          return;
        end
        rx_phase = PH_SEQ;
        rx_count = 8'd0;
        rx_gap   = 8'd0;
        rx_sum   = {8'h00, BYTE_SOH};
        rx_bcast = 1'b1;
        rx_match = 1'b1;
        rx_seq   = 8'd0;
        rx_len   = 8'd0;
        rx_tail  = 32'd0;
      end
      PH_SEQ: begin
        if (rx_count == 8'd0) begin
          rx_seq   = b;
          rx_count = 8'd1;
        end else if (b != ~rx_seq) begin
          push_rx_error();
        end else begin
          rx_count = 8'd0;
          rx_phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        slot = rx_count[2:0];
        if (slot < 3'd4) begin
          rx_bcast = rx_bcast && (b == BYTE_BCAST);
          rx_match = rx_match && (b == own_byte(int'(slot)));
          if (!rx_bcast && !rx_match) begin
            push_rx_error();
            return;
          end
        end else begin
          rx_tail = {rx_tail[23:0], b};
          if (slot < 3'd7 && !rx_bcast && b != own_byte(int'(slot))) begin
            push_rx_error();
            return;
          end
        end
        if (slot == 3'd7) begin
          rx_count = 8'd0;
          rx_phase = PH_LEN;
        end else begin
          rx_count = {5'd0, slot} + 8'd1;
        end
      end
      PH_LEN: begin
        if (b > max_len) begin
          push_rx_error();
        end else begin
          rx_len   = b;
          rx_count = 8'd0;
          rx_phase = (b == 8'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        push_frame_word(KIND_DATA, b, rx_count);
        rx_count = rx_count + 8'd1;
        if (rx_count >= rx_len) begin
          rx_count = 8'd0;
          rx_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        rx_sum = rx_sum - b;
        if (rx_count == 8'd0) begin
          rx_chk_hi = b;
          rx_count  = 8'd1;
        end else begin
          got      = {rx_chk_hi, b};
          rx_count = 8'd0;
          rx_phase = PH_HUNT;
          push_frame_word((got == rx_sum) ? KIND_GOOD : KIND_BAD, rx_len, 8'd0);
        end
      end
      default: rx_phase = (b == BYTE_REQ) ? PH_PRE : PH_HUNT;
    endcase
  endfunction

  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
  endfunction

  // Send one word; returns at the edge that accepted it, valid left high
  task automatic send_word(input logic op, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_frame(op, b);
    words_sent++;
  endtask

  // Write all four registers back to back
  task automatic load_config(input logic [31:0] high, input logic [23:0] mid,
                             input logic [7:0] maxl, input logic [7:0] gap);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_OWN_HIGH;
    cfg_wdata <= high;
    @(posedge clk);
    cfg_addr  <= CFG_OWN_MID;
    cfg_wdata <= {8'h00, mid};
    @(posedge clk);
    cfg_addr  <= CFG_MAX_LEN;
    cfg_wdata <= {24'd0, maxl};
    @(posedge clk);
    cfg_addr  <= CFG_GAP_LIMIT;
    cfg_wdata <= {24'd0, gap};
    @(posedge clk);
    cfg_we   <= 1'b0;
    own_high = high;
    own_mid  = mid;
    max_len  = maxl;
    gap_lim  = gap;
  endtask

  // Drain: all results back, then let silent words leave the pipeline
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One request frame after a preamble, with optional flaw and in-frame ticks
  task automatic send_frame(input int len, input addr_mode_t mode, input flaw_t flaw);
    logic [7:0]  fb[$];
    logic [7:0]  seq;
    logic [7:0]  cpl;
    logic [7:0]  flip;
    logic [7:0]  a;
    logic [15:0] csum;
    int          stop;
    int          near_slot;
    seq  = 8'($urandom_range(0, 255));
    flip = 8'($urandom_range(1, 255));
    cpl  = ~seq;
    if (flaw == FL_CPL) cpl = cpl ^ flip;
    fb.push_back(BYTE_SOH);
    fb.push_back(seq);
    fb.push_back(cpl);
    near_slot = (mode == ADDR_NEAR) ? $urandom_range(0, 6) : -1;
    for (int k = 0; k < 8; k++) begin
      a = 8'($urandom_range(0, 255));
      if (mode == ADDR_BCAST && k < 4) a = BYTE_BCAST;
      if ((mode == ADDR_OWN || mode == ADDR_NEAR) && k < 7) a = own_byte(k);
      if (k == near_slot) a = a ^ flip;
      fb.push_back(a);
    end
    fb.push_back(len[7:0]);
    repeat (len) fb.push_back(8'($urandom_range(0, 255)));
    csum = 16'd0;
    foreach (fb[k]) csum = csum + fb[k];
    if (flaw == FL_CSUM) csum = csum ^ {flip, flip ^ 8'h5A};
    fb.push_back(csum[15:8]);
    fb.push_back(csum[7:0]);
    stop = (flaw == FL_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();

    repeat ($urandom_range(1, 3)) send_word(OP_BYTE, BYTE_REQ);
    for (int k = 0; k < stop; k++) begin
      // short pauses inside the frame; reach the limit when it is low
      if (k > 0 && $urandom_range(0, 11) == 0)
        repeat ($urandom_range(1, 2)) send_word(OP_TICK, 8'($urandom_range(0, 255)));
      send_word(OP_BYTE, fb[k]);
    end
    // a cut frame may time out on the gap
    if (flaw == FL_CUT && gap_lim <= 8'd8 && $urandom_range(0, 1) == 1)
      repeat (gap_lim) send_word(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Hunt noise, repeated preamble, bad byte after preamble, short broadcast frame
  task automatic test_directed();
    logic [7:0]  fb[$];
    logic [15:0] csum;
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_BYTE, BYTE_REQ);
    send_word(OP_BYTE, BYTE_REQ);
    send_word(OP_TICK, 8'h00);
    send_word(OP_BYTE, 8'h00);
    fb = '{BYTE_SOH, 8'h00, 8'hFF, BYTE_BCAST, BYTE_BCAST, BYTE_BCAST, BYTE_BCAST,
           8'h80, 8'h7F, 8'h00, 8'hFF, 8'h00};
    csum = 16'd0;
    foreach (fb[k]) csum = csum + fb[k];
    fb.push_back(csum[15:8]);
    fb.push_back(csum[7:0]);
    send_word(OP_BYTE, BYTE_REQ);
    foreach (fb[k]) begin
      if (k == 5) send_word(OP_TICK, 8'h5A);
      send_word(OP_BYTE, fb[k]);
    end
  endtask

  // Longest frame, then a gap that runs the timer to its top
  task automatic test_gap_and_length_limits();
    send_frame(255, ADDR_OWN, FL_NONE);
    send_word(OP_BYTE, BYTE_REQ);
    send_word(OP_BYTE, BYTE_SOH);
    repeat (258) send_word(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_frames(input int target, input bit with_idle);
    int         r;
    int         len;
    addr_mode_t mode;
    flaw_t      flaw;
    while (words_sent < target) begin
      idle_on  = with_idle && ($urandom_range(0, 3) != 0);
      stall_on = with_idle && ($urandom_range(0, 3) != 0);
      // line noise between frames
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      r = $urandom_range(0, 19);
      mode = (r < 9) ? ADDR_OWN : (r < 15) ? ADDR_BCAST : (r < 18) ? ADDR_NEAR : ADDR_RANDOM;
      r = $urandom_range(0, 19);
      flaw = (r < 14) ? FL_NONE : (r < 16) ? FL_CSUM : (r < 17) ? FL_CPL : FL_CUT;
      r = $urandom_range(0, 39);
      if (r == 0 && max_len != 8'hFF)
        len = $urandom_range(int'(max_len) + 1, 255);
      else if (r == 1)
        len = $urandom_range(0, int'(max_len));
      else
        len = $urandom_range(0, (max_len < 8'd8) ? int'(max_len) : 8);
      send_frame(len, mode, flaw);
    end
  endtask

  // Result side: check each accepted word, stall in bursts
  task automatic check_result();
    res_t want;
    if (frame_results_q.size() == 0) begin
      note_mismatch("word with none expected, kind", 64'd0, 64'(out_tuser));
      return;
    end
    want = frame_results_q.pop_front();
    if (out_tuser != want.kind)
      note_mismatch("kind", 64'(want.kind), 64'(out_tuser));
    if (out_tdata[7:0] != want.value)
      note_mismatch("value", 64'(want.value), 64'(out_tdata[7:0]));
    if (out_tdata[15:8] != want.position)
      note_mismatch("position", 64'(want.position), 64'(out_tdata[15:8]));
    if (out_tdata[23:16] != want.sequence_res)
      note_mismatch("sequence", 64'(want.sequence_res), 64'(out_tdata[23:16]));
    if (out_tdata[24] != want.broadcast)
      note_mismatch("broadcast", 64'(want.broadcast), 64'(out_tdata[24]));
    if (out_tdata[88:25] != want.address)
      note_mismatch("address", want.address, out_tdata[88:25]);
  endtask

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_result();
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int spin;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tuser  <= OP_BYTE;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_OWN_HIGH;
    cfg_wdata <= 32'd0;
    rst_n     <= 1'b0;
    // receiver copy after reset
    own_high  = 32'd0;
    own_mid   = 24'd0;
    max_len   = MAX_LEN_RST;
    gap_lim   = GAP_LIMIT_RST;
    rx_phase  = PH_HUNT;
    rx_count  = 8'd0;
    rx_bcast  = 1'b0;
    rx_match  = 1'b0;
    rx_seq    = 8'd0;
    rx_len    = 8'd0;
    rx_sum    = 16'd0;
    rx_chk_hi = 8'd0;
    rx_tail   = 32'd0;
    rx_gap    = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_frames(350, 1'b1);

    wait_idle();
    load_config($urandom, 24'($urandom_range(0, 24'hFF_FFFF)), 8'd255, 8'd255);
    test_gap_and_length_limits();
    test_random_frames(1000, 1'b1);

    wait_idle();
    load_config(32'hFFFF_FFFF, 24'hFF_FFFF, 8'd0, 8'd1);
    test_random_frames(1200, 1'b1);

    wait_idle();
    load_config($urandom, 24'($urandom_range(0, 24'hFF_FFFF)), 8'($urandom_range(1, 40)),
                8'($urandom_range(2, 6)));
    test_random_frames(1600, 1'b1);

    wait_idle();
    load_config($urandom, 24'($urandom_range(0, 24'hFF_FFFF)), MAX_LEN_RST, GAP_LIMIT_RST);
    test_random_frames(1950, 1'b0);

    // drain with a bound
    in_tvalid <= 1'b0;
    for (spin = 0; spin < 5000 && frame_results_q.size() != 0; spin++) @(posedge clk);
    repeat (8) @(posedge clk);
    mismatches += frame_results_q.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
